// ----- rtl/acds_pkg.sv -----
// Shared types and constants of the accelerometer calibration and smoothing block.
package acds_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LOAD = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_POST = 9'b000001000,
        ST_CHK  = 9'b000010000,
        ST_MUL1 = 9'b000100000,
        ST_MUL2 = 9'b001000000,
        ST_RND  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    // What the running division computes.
    typedef enum logic [2:0] {
        PH_TOG  = 3'b001,
        PH_AVG  = 3'b010,
        PH_NORM = 3'b100
    } phase_t;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_CALIB = 2'd0;
    localparam logic [1:0] OP_MEAS  = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Register indexes, paddr[3:2].
    localparam logic [1:0] REG_CALIB_SAMPLES = 2'd0;
    localparam logic [1:0] REG_MAX_G         = 2'd1;
    localparam logic [1:0] REG_DEAD_ZONE     = 2'd2;
    localparam logic [1:0] REG_SMOOTH        = 2'd3;

    // Axis indexes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Q3.12 scaling: g = round(raw * G_SPAN / FS) - G_BIAS.
    localparam int G_SPAN = 20480;
    localparam int G_BIAS = 10240;
    localparam int ONE_G  = 4096;
    localparam int Q12    = 4096;

    // Register reset values.
    localparam logic [10:0] CALIB_SAMPLES_RST = 11'd16;
    localparam logic [14:0] MAX_G_RST         = 15'd3277;
    localparam logic [14:0] DEAD_ZONE_RST     = 15'd410;
    localparam logic [12:0] SMOOTH_RST        = 13'd819;

endpackage

// ----- rtl/accel_calibrate_deadzone_smooth.sv -----
// Accelerometer offset calibration, measurement, deadzone and smoothing filter.
// A shared divider resolves two quotient bits per cycle. Measure takes 3 divisions,
// calibrate adds 3 more when a run completes, and movement takes one division and
// two passes through the multiplier.
// One word at a time; reset clears all sums, offsets, filter and registers to defaults.
module accel_calibrate_deadzone_smooth #(
    parameter int MAX_CAL_SAMPLES = 1024,
    parameter int ADC_BITS        = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // raw_x[9:0], raw_y[19:10], raw_z[29:20], g_value[45:30]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // g_x[15:0], g_y[31:16], g_z[47:32], movement[61:48]
    output logic        m_axis_tuser,   // calibrated
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Full scale of the converter and the largest effective sample count.
    localparam int FS    = (1 << ADC_BITS) - 1;
    localparam int NMAX  = (MAX_CAL_SAMPLES < 2047) ? MAX_CAL_SAMPLES : 2047;
    localparam int SUM_A = $clog2(NMAX * 10240 + 1) + 1;
    localparam int SUM_W = (SUM_A > 17) ? SUM_A : 17;
    localparam int TG_W  = ADC_BITS + 15;
    localparam int NRM_W = 28;
    localparam int DW_A  = (TG_W > SUM_W) ? TG_W : SUM_W;
    localparam int DW_B  = (DW_A > NRM_W) ? DW_A : NRM_W;
    localparam int DW    = DW_B + (DW_B % 2);
    localparam int QW    = (ADC_BITS > 15) ? ADC_BITS : 15;
    localparam int STEPS = DW / 2;
    localparam int STEP_W = $clog2(STEPS);
    localparam int RW    = (ADC_BITS > 10) ? ADC_BITS : 10;

    // Saturate a 17-bit difference to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -17'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [10:0] calib_samples_reg, calib_samples_next;
    logic [14:0] max_g_reg, max_g_next;
    logic [14:0] dead_zone_reg, dead_zone_next;
    logic [12:0] smooth_reg, smooth_next;

    // Sequencer.
    acds_pkg::state_t state_reg, state_next;
    acds_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       axis_reg, axis_next;
    logic [1:0]       op_reg, op_next;

    // Architectural state.
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic [10:0]             count_reg, count_next;
    logic signed [15:0]      off_reg [3];
    logic signed [15:0]      off_next [3];
    logic signed [13:0]      filt_reg, filt_next;
    logic                    done_reg, done_next;

    // Item payload and intermediate values.
    logic [ADC_BITS-1:0]     raw_reg [3];
    logic [ADC_BITS-1:0]     raw_next [3];
    logic [RW-1:0]           raw_w [3];
    logic signed [15:0]      gv_reg, gv_next;
    logic signed [15:0]      g_reg [3];
    logic signed [15:0]      g_next [3];
    logic signed [13:0]      mv_reg, mv_next;
    logic signed [25:0]      acc_reg, acc_next;
    logic                    active_reg, active_next;

    // Shared divider.
    logic [DW-1:0]     num_reg, num_next;
    logic [QW-1:0]     den_reg, den_next;
    logic [QW-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;

    // Output word.
    logic               ovalid_reg, ovalid_next;
    logic signed [15:0] ogx_reg, ogx_next;
    logic signed [15:0] ogy_reg, ogy_next;
    logic signed [15:0] ogz_reg, ogz_next;
    logic signed [13:0] omv_reg, omv_next;
    logic               ocal_reg, ocal_next;

    // Effective register values.
    logic [10:0] n_eff;
    logic [14:0] m_eff;
    logic [12:0] s_eff;

    always_comb
    begin
        if (calib_samples_reg == 11'd0)
        begin
            n_eff = 11'd1;
        end
        else if (32'(calib_samples_reg) > 32'(MAX_CAL_SAMPLES))
        begin
            n_eff = 11'(MAX_CAL_SAMPLES);
        end
        else
        begin
            n_eff = calib_samples_reg;
        end
        m_eff = (max_g_reg == 15'd0) ? 15'd1 : max_g_reg;
        s_eff = (smooth_reg > 13'(acds_pkg::Q12)) ? 13'(acds_pkg::Q12) : smooth_reg;
    end

    // Deadzone test and clamp of the movement input.
    logic signed [16:0] gv17, dz17, m17, clamp17;
    logic               dz_inside;
    logic [14:0]        clamp_mag;

    always_comb
    begin
        gv17 = {gv_reg[15], gv_reg};
        dz17 = {2'b00, dead_zone_reg};
        m17  = {2'b00, m_eff};
        dz_inside = (gv17 > -dz17) && (gv17 < dz17);
        if (gv17 > m17)
        begin
            clamp17 = m17;
        end
        else if (gv17 < -m17)
        begin
            clamp17 = -m17;
        end
        else
        begin
            clamp17 = gv17;
        end
        clamp_mag = clamp17[16] ? 15'(-clamp17) : clamp17[14:0];
    end

    // Two restoring division steps per cycle.
    logic [QW:0]   t1, t2;
    logic [QW-1:0] r1, r2;
    logic          b1, b2;
    logic [DW-1:0] n1, n2;

    always_comb
    begin
        t1 = {rem_reg, num_reg[DW-1]};
        b1 = (t1 >= {1'b0, den_reg});
        r1 = b1 ? QW'(t1 - {1'b0, den_reg}) : t1[QW-1:0];
        n1 = {num_reg[DW-2:0], b1};
        t2 = {r1, n1[DW-1]};
        b2 = (t2 >= {1'b0, den_reg});
        r2 = b2 ? QW'(t2 - {1'b0, den_reg}) : t2[QW-1:0];
        n2 = {n1[DW-2:0], b2};
    end

    // Quotient views used after a division.
    logic [15:0]        quo;
    logic signed [15:0] quo_signed;
    logic signed [15:0] g_q;

    always_comb
    begin
        quo        = num_reg[15:0];
        quo_signed = neg_reg ? -$signed(quo) : $signed(quo);
        g_q        = 16'($signed({1'b0, quo}) - 17'sd10240);
    end

    // Shared multiplier for the smoothing filter.
    logic signed [13:0] mul_a, mul_b;
    logic signed [27:0] prod;

    always_comb
    begin
        if (state_reg == acds_pkg::ST_MUL1)
        begin
            mul_a = filt_reg;
            mul_b = $signed({1'b0, 13'(13'(acds_pkg::Q12) - s_eff)});
        end
        else
        begin
            mul_a = mv_reg;
            mul_b = $signed({1'b0, s_eff});
        end
        prod = mul_a * mul_b;
    end

    // Rounded divide of the filter sum by 4096, ties away from zero.
    logic [25:0]        acc_mag;
    logic [25:0]        acc_rnd;
    logic signed [13:0] filt_rnd;

    always_comb
    begin
        acc_mag  = acc_reg[25] ? 26'(-acc_reg) : 26'(acc_reg);
        acc_rnd  = acc_mag + 26'd2048;
        filt_rnd = acc_reg[25] ? -$signed({1'b0, acc_rnd[24:12]})
                               : $signed({1'b0, acc_rnd[24:12]});
    end

    // Divider load request from the sequencer.
    logic                ld_en;
    acds_pkg::phase_t    ld_phase;
    logic [1:0]          ld_axis;
    logic [DW-1:0]       ld_num;
    logic [QW-1:0]       ld_den;
    logic                ld_neg;
    logic [SUM_W-1:0]    sum_mag;
    logic signed [SUM_W-1:0] ld_sum;

    // Measurement differences.
    logic signed [16:0] dx, dy, dz;

    always_comb
    begin
        raw_w[0] = RW'(s_axis_tdata[9:0]);
        raw_w[1] = RW'(s_axis_tdata[19:10]);
        raw_w[2] = RW'(s_axis_tdata[29:20]);

        state_next  = state_reg;
        phase_next  = phase_reg;
        axis_next   = axis_reg;
        op_next     = op_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        off_next    = off_reg;
        filt_next   = filt_reg;
        done_next   = done_reg;
        raw_next    = raw_reg;
        gv_next     = gv_reg;
        g_next      = g_reg;
        mv_next     = mv_reg;
        acc_next    = acc_reg;
        active_next = active_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg;
        ogx_next    = ogx_reg;
        ogy_next    = ogy_reg;
        ogz_next    = ogz_reg;
        omv_next    = omv_reg;
        ocal_next   = ocal_reg;
        ld_en       = 1'b0;
        ld_phase    = acds_pkg::PH_TOG;
        ld_axis     = acds_pkg::AXIS_X;

        dx = $signed({g_reg[0][15], g_reg[0]}) - $signed({off_reg[0][15], off_reg[0]});
        dy = $signed({g_reg[1][15], g_reg[1]}) - $signed({off_reg[1][15], off_reg[1]});
        dz = $signed({g_reg[2][15], g_reg[2]}) - $signed({off_reg[2][15], off_reg[2]});

        if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            acds_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    raw_next[0] = raw_w[0][ADC_BITS-1:0];
                    raw_next[1] = raw_w[1][ADC_BITS-1:0];
                    raw_next[2] = raw_w[2][ADC_BITS-1:0];
                    gv_next     = $signed(s_axis_tdata[45:30]);
                    state_next  = acds_pkg::ST_LOAD;
                end
            end
            acds_pkg::ST_LOAD:
            begin
                active_next = 1'b0;
                case (op_reg) inside
                    acds_pkg::OP_CALIB, acds_pkg::OP_MEAS:
                    begin
                        ld_en      = 1'b1;
                        ld_phase   = acds_pkg::PH_TOG;
                        ld_axis    = acds_pkg::AXIS_X;
                        state_next = acds_pkg::ST_DIV;
                    end
                    acds_pkg::OP_MOVE:
                    begin
                        if (dz_inside)
                        begin
                            state_next = acds_pkg::ST_FIN;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            ld_en       = 1'b1;
                            ld_phase    = acds_pkg::PH_NORM;
                            state_next  = acds_pkg::ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = acds_pkg::ST_FIN;
                    end
                endcase
            end
            acds_pkg::ST_DIV:
            begin
                num_next  = n2;
                rem_next  = r2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = acds_pkg::ST_POST;
                end
            end
            acds_pkg::ST_POST:
            begin
                case (phase_reg)
                    acds_pkg::PH_TOG:
                    begin
                        g_next[axis_reg] = g_q;
                        if (axis_reg != acds_pkg::AXIS_Z)
                        begin
                            ld_en      = 1'b1;
                            ld_phase   = acds_pkg::PH_TOG;
                            ld_axis    = axis_reg + 2'd1;
                            state_next = acds_pkg::ST_DIV;
                        end
                        else if (op_reg == acds_pkg::OP_CALIB)
                        begin
                            sum_next[0] = sum_reg[0] + SUM_W'(g_reg[0]);
                            sum_next[1] = sum_reg[1] + SUM_W'(g_reg[1]);
                            sum_next[2] = sum_reg[2] + SUM_W'(g_q);
                            count_next  = count_reg + 11'd1;
                            state_next  = acds_pkg::ST_CHK;
                        end
                        else
                        begin
                            state_next = acds_pkg::ST_FIN;
                        end
                    end
                    acds_pkg::PH_AVG:
                    begin
                        if (axis_reg == acds_pkg::AXIS_Z)
                        begin
                            off_next[axis_reg] = quo_signed - 16'sd4096;
                            sum_next[0] = '0;
                            sum_next[1] = '0;
                            sum_next[2] = '0;
                            count_next  = 11'd0;
                            done_next   = 1'b1;
                            state_next  = acds_pkg::ST_FIN;
                        end
                        else
                        begin
                            off_next[axis_reg] = quo_signed;
                            ld_en      = 1'b1;
                            ld_phase   = acds_pkg::PH_AVG;
                            ld_axis    = axis_reg + 2'd1;
                            state_next = acds_pkg::ST_DIV;
                        end
                    end
                    acds_pkg::PH_NORM:
                    begin
                        mv_next    = 14'(quo_signed);
                        state_next = acds_pkg::ST_MUL1;
                    end
                    default:
                    begin
                        state_next = acds_pkg::ST_FIN;
                    end
                endcase
            end
            acds_pkg::ST_CHK:
            begin
                // The count may already exceed a smaller count written meanwhile.
                if (count_reg >= n_eff)
                begin
                    ld_en      = 1'b1;
                    ld_phase   = acds_pkg::PH_AVG;
                    ld_axis    = acds_pkg::AXIS_X;
                    state_next = acds_pkg::ST_DIV;
                end
                else
                begin
                    state_next = acds_pkg::ST_FIN;
                end
            end
            acds_pkg::ST_MUL1:
            begin
                acc_next   = 26'(prod);
                state_next = acds_pkg::ST_MUL2;
            end
            acds_pkg::ST_MUL2:
            begin
                acc_next   = acc_reg + 26'(prod);
                state_next = acds_pkg::ST_RND;
            end
            acds_pkg::ST_RND:
            begin
                filt_next  = filt_rnd;
                state_next = acds_pkg::ST_FIN;
            end
            acds_pkg::ST_FIN:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    if (op_reg == acds_pkg::OP_MEAS)
                    begin
                        ogx_next = sat16(dx);
                        ogy_next = sat16(dy);
                        ogz_next = sat16(dz);
                    end
                    else
                    begin
                        ogx_next = '0;
                        ogy_next = '0;
                        ogz_next = '0;
                    end
                    omv_next   = (op_reg == acds_pkg::OP_MOVE && active_reg) ? filt_reg : '0;
                    ocal_next  = done_reg;
                    state_next = acds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acds_pkg::ST_IDLE;
            end
        endcase

        // Operands of the division that starts next.
        ld_sum  = sum_reg[ld_axis];
        sum_mag = ld_sum[SUM_W-1] ? SUM_W'(-ld_sum) : SUM_W'(ld_sum);
        case (ld_phase)
            acds_pkg::PH_AVG:
            begin
                ld_num = DW'(sum_mag) + DW'(n_eff >> 1);
                ld_den = QW'(n_eff);
                ld_neg = ld_sum[SUM_W-1];
            end
            acds_pkg::PH_NORM:
            begin
                ld_num = DW'({clamp_mag, 12'd0}) + DW'(m_eff >> 1);
                ld_den = QW'(m_eff);
                ld_neg = clamp17[16];
            end
            default:
            begin
                ld_num = DW'(raw_reg[ld_axis]) * DW'(acds_pkg::G_SPAN) + DW'(FS / 2);
                ld_den = QW'(FS);
                ld_neg = 1'b0;
            end
        endcase

        if (ld_en)
        begin
            num_next   = ld_num;
            den_next   = ld_den;
            rem_next   = '0;
            step_next  = '0;
            neg_next   = ld_neg;
            phase_next = ld_phase;
            axis_next  = ld_axis;
        end

        // Register writes land on the access cycle.
        calib_samples_next = calib_samples_reg;
        max_g_next         = max_g_reg;
        dead_zone_next     = dead_zone_reg;
        smooth_next        = smooth_reg;
        if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                acds_pkg::REG_CALIB_SAMPLES: calib_samples_next = pwdata[10:0];
                acds_pkg::REG_MAX_G:         max_g_next         = pwdata[14:0];
                acds_pkg::REG_DEAD_ZONE:     dead_zone_next     = pwdata[14:0];
                acds_pkg::REG_SMOOTH:        smooth_next        = pwdata[12:0];
            endcase
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= acds_pkg::ST_IDLE;
            phase_reg         <= acds_pkg::PH_TOG;
            axis_reg          <= acds_pkg::AXIS_X;
            op_reg            <= acds_pkg::OP_NONE;
            sum_reg[0]        <= '0;
            sum_reg[1]        <= '0;
            sum_reg[2]        <= '0;
            count_reg         <= '0;
            off_reg[0]        <= '0;
            off_reg[1]        <= '0;
            off_reg[2]        <= '0;
            filt_reg          <= '0;
            done_reg          <= 1'b0;
            active_reg        <= 1'b0;
            step_reg          <= '0;
            ovalid_reg        <= 1'b0;
            calib_samples_reg <= acds_pkg::CALIB_SAMPLES_RST;
            max_g_reg         <= acds_pkg::MAX_G_RST;
            dead_zone_reg     <= acds_pkg::DEAD_ZONE_RST;
            smooth_reg        <= acds_pkg::SMOOTH_RST;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            axis_reg          <= axis_next;
            op_reg            <= op_next;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            off_reg           <= off_next;
            filt_reg          <= filt_next;
            done_reg          <= done_next;
            active_reg        <= active_next;
            step_reg          <= step_next;
            ovalid_reg        <= ovalid_next;
            calib_samples_reg <= calib_samples_next;
            max_g_reg         <= max_g_next;
            dead_zone_reg     <= dead_zone_next;
            smooth_reg        <= smooth_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        gv_reg  <= gv_next;
        g_reg   <= g_next;
        mv_reg  <= mv_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        ogx_reg <= ogx_next;
        ogy_reg <= ogy_next;
        ogz_reg <= ogz_next;
        omv_reg <= omv_next;
        ocal_reg <= ocal_next;
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            acds_pkg::REG_CALIB_SAMPLES: prdata = 32'(calib_samples_reg);
            acds_pkg::REG_MAX_G:         prdata = 32'(max_g_reg);
            acds_pkg::REG_DEAD_ZONE:     prdata = 32'(dead_zone_reg);
            acds_pkg::REG_SMOOTH:        prdata = 32'(smooth_reg);
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == acds_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, omv_reg, ogz_reg, ogy_reg, ogx_reg};
    assign m_axis_tuser  = ocal_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the accelerometer calibration, deadzone and smoothing block.
module testbench;

    import acds_pkg::*;

    localparam int    ADC_FULL        = 1023;
    localparam int    SPAN_Q12        = 20480;
    localparam int    BIAS_Q12        = 10240;
    localparam int    GRAVITY_Q12     = 4096;
    localparam int    UNITY_Q12       = 4096;
    localparam int    CAL_LIMIT       = 1024;
    localparam int    LIMIT_CYCLES    = 1000000;
    localparam int    HOLD_OFF_CYCLES = 400;
    localparam int    TAIL_CYCLES     = 200;

    // Sender and receiver pacing modes.
    localparam int    PACE_NONE = 0;
    localparam int    PACE_SEND = 1;
    localparam int    PACE_RECV = 2;
    localparam int    PACE_BOTH = 3;

    typedef struct {
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] gz;
        logic [13:0] mv;
        logic        cal;
    } accel_word_t;

    // Tracks calibration sums, offsets and the filter, and holds the output words
    // still owed by the block, oldest first.
    class accel_scoreboard;
        logic [10:0]  samples_cfg;
        logic [14:0]  max_g_cfg;
        logic [14:0]  dead_zone_cfg;
        logic [12:0]  smooth_cfg;
        longint       axis_sum[3];
        longint       axis_offset[3];
        longint       filter_q12;
        int           sample_count;
        bit           calib_done;
        accel_word_t  owed_words[$];
        int           errors;
        int           checked;
        int           calibrations;
        int           moves;
        int           measures;

        function void reset_state();
            samples_cfg   = 11'd16;
            max_g_cfg     = 15'd3277;
            dead_zone_cfg = 15'd410;
            smooth_cfg    = 13'd819;
            foreach (axis_sum[i])
            begin
                axis_sum[i]    = 0;
                axis_offset[i] = 0;
            end
            filter_q12   = 0;
            sample_count = 0;
            calib_done   = 1'b0;
            owed_words.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CALIB_SAMPLES: samples_cfg   = value[10:0];
                REG_MAX_G:         max_g_cfg     = value[14:0];
                REG_DEAD_ZONE:     dead_zone_cfg = value[14:0];
                REG_SMOOTH:        smooth_cfg    = value[12:0];
                default: ;
            endcase
        endfunction

        // Rounds to nearest with ties away from zero.
        function longint round_div(longint num, longint den);
            if (num >= 0)
                return (num + den / 2) / den;
            return -((-num + den / 2) / den);
        endfunction

        function longint clip16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function longint adc_to_g(logic [9:0] raw);
            longint r;
            r = raw;
            return (r * SPAN_Q12 + ADC_FULL / 2) / ADC_FULL - BIAS_Q12;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void predict_word(logic [1:0] op, logic [9:0] rx, logic [9:0] ry,
                                   logic [9:0] rz, logic [15:0] gv16);
            longint      g[3];
            longint      gv;
            longint      n;
            longint      lim;
            longint      wt;
            longint      dz;
            longint      c;
            longint      mv;
            accel_word_t w;
            g[0] = adc_to_g(rx);
            g[1] = adc_to_g(ry);
            g[2] = adc_to_g(rz);
            gv   = $signed(gv16);
            w    = '{default: '0};
            case (op)
                OP_CALIB:
                begin
                    n = samples_cfg;
                    if (n == 0)
                        n = 1;
                    if (n > CAL_LIMIT)
                        n = CAL_LIMIT;
                    foreach (g[i])
                        axis_sum[i] += g[i];
                    sample_count++;
                    // A lowered sample count completes a run that already passed it.
                    if (sample_count >= n)
                    begin
                        foreach (g[i])
                        begin
                            axis_offset[i] = round_div(axis_sum[i], n);
                            axis_sum[i]    = 0;
                        end
                        axis_offset[2] -= GRAVITY_Q12;
                        sample_count = 0;
                        calib_done   = 1'b1;
                        calibrations++;
                    end
                end
                OP_MEAS:
                begin
                    w.gx = 16'(clip16(g[0] - axis_offset[0]));
                    w.gy = 16'(clip16(g[1] - axis_offset[1]));
                    w.gz = 16'(clip16(g[2] - axis_offset[2]));
                    measures++;
                end
                OP_MOVE:
                begin
                    dz = dead_zone_cfg;
                    moves++;
                    // Inside the deadzone the output is zero and the filter holds.
                    if (!(gv > -dz && gv < dz))
                    begin
                        lim = (max_g_cfg == 0) ? 1 : max_g_cfg;
                        wt  = (smooth_cfg > UNITY_Q12) ? UNITY_Q12 : smooth_cfg;
                        c   = gv;
                        if (c > lim)
                            c = lim;
                        if (c < -lim)
                            c = -lim;
                        mv = round_div(c * UNITY_Q12, lim);
                        filter_q12 = round_div(filter_q12 * (UNITY_Q12 - wt) + mv * wt,
                                               UNITY_Q12);
                        w.mv = 14'(filter_q12);
                    end
                end
                default: ;
            endcase
            w.cal = calib_done;
            owed_words.push_back(w);
        endfunction

        function void check_field(string name, logic [15:0] expv, logic [15:0] actv);
            if (actv !== expv)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void compare_word(logic [63:0] data, logic user);
            accel_word_t e;
            if (owed_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
                         $time, data, user);
                errors++;
                return;
            end
            e = owed_words.pop_front();
            checked++;
            check_field("g_x", e.gx, data[15:0]);
            check_field("g_y", e.gy, data[31:16]);
            check_field("g_z", e.gz, data[47:32]);
            check_field("movement", {2'b00, e.mv}, {2'b00, data[61:48]});
            check_field("calibrated", {15'd0, e.cal}, {15'd0, user});
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // raw_x[9:0], raw_y[19:10], raw_z[29:20], g_value[45:30]
    logic [1:0]  s_axis_tuser;    // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // g_x[15:0], g_y[31:16], g_z[47:32], movement[61:48]
    logic        m_axis_tuser;    // calibrated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    accel_scoreboard sb;
    int          gap_pct;
    int          stall_pct;
    bit          hold_off_req;
    int          cycle_count;
    int          words_sent;
    int          settings_run;
    int          cur_dead_zone;
    int          cur_max_g;

    accel_calibrate_deadzone_smooth i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here on request.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.compare_word(m_axis_tdata, m_axis_tuser);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one word; with hold set, first waits with valid low until nothing is owed.
    task automatic send_word(logic [1:0] op, logic [9:0] rx, logic [9:0] ry, logic [9:0] rz,
                             logic [15:0] gv, bit hold);
        if (hold)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            while (sb.pending() != 0)
                @(negedge clk);
        end
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, gv, rz, ry, rx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.predict_word(op, rx, ry, rz, gv);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_pace(int mode);
        case (mode)
            PACE_SEND: begin gap_pct = 66; stall_pct = 0;  end
            PACE_RECV: begin gap_pct = 0;  stall_pct = 66; end
            PACE_BOTH: begin gap_pct = 6;  stall_pct = 6;  end
            default:   begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    function automatic logic [9:0] pick_raw();
        if ($urandom_range(9) < 3)
        begin
            case ($urandom_range(3))
                0:       return 10'd0;
                1:       return 10'd1023;
                2:       return 10'd512;
                default: return 10'd511;
            endcase
        end
        return 10'($urandom_range(1023));
    endfunction

    // Acceleration values cluster around the deadzone edge and the clamp limit.
    function automatic logic [15:0] pick_g();
        int v;
        int d;
        d = int'($urandom_range(2)) - 1;
        case ($urandom_range(5))
            2:       v = cur_dead_zone + d;
            3:       v = -(cur_dead_zone + d);
            4:       v = ($urandom_range(1) != 0) ? cur_max_g + d : -(cur_max_g + d);
            5:       v = int'($urandom_range(2 * cur_dead_zone + 2)) - cur_dead_zone - 1;
            default: v = int'($urandom_range(65535));
        endcase
        return v[15:0];
    endfunction

    task automatic run_setting(int samples, int max_g, int dead_zone, int smooth, int words,
                               int mode, bit calib_heavy, int pause_at, int hold_off_at);
        int         r;
        logic [1:0] op;
        write_reg(REG_CALIB_SAMPLES, samples);
        write_reg(REG_MAX_G, max_g);
        write_reg(REG_DEAD_ZONE, dead_zone);
        write_reg(REG_SMOOTH, smooth);
        cur_max_g     = max_g;
        cur_dead_zone = dead_zone;
        set_pace(mode);
        settings_run++;
        for (int k = 0; k < words; k++)
        begin
            r = $urandom_range(99);
            if (calib_heavy)
                op = (r < 95) ? OP_CALIB : (r < 98) ? OP_MEAS : OP_MOVE;
            else
                op = (r < 35) ? OP_CALIB : (r < 65) ? OP_MEAS : (r < 95) ? OP_MOVE : OP_NONE;
            if (k == hold_off_at)
                hold_off_req = 1'b1;
            send_word(op, pick_raw(), pick_raw(), pick_raw(), pick_g(), k == pause_at);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CALIB;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_off_req  = 1'b0;
        words_sent    = 0;
        settings_run  = 1;
        cur_max_g     = 3277;
        cur_dead_zone = 410;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words on the reset register values: ADC extremes, deadzone and
        // clamp edges, the unused operation.
        send_word(OP_MEAS, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0);
        send_word(OP_MEAS, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b0);
        send_word(OP_MEAS, 10'd1, 10'd511, 10'd512, 16'h0000, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'h7FFF, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'h8000, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'd0, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'd410, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, -16'sd410, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'd409, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, -16'sd409, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'd3277, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, -16'sd3277, 1'b0);
        send_word(OP_MOVE, 10'd0, 10'd0, 10'd0, 16'd3278, 1'b0);
        send_word(OP_NONE, 10'd1023, 10'd0, 10'd1023, 16'h5A5A, 1'b0);
        drain();

        // Two-sample calibrations: a full run, then a second one replacing the offsets.
        write_reg(REG_CALIB_SAMPLES, 32'd2);
        send_word(OP_CALIB, 10'd0, 10'd0, 10'd0, 16'h0000, 1'b0);
        send_word(OP_CALIB, 10'd1023, 10'd1023, 10'd1023, 16'h0000, 1'b0);
        send_word(OP_MEAS, 10'd0, 10'd1023, 10'd512, 16'h0000, 1'b0);
        send_word(OP_CALIB, 10'd1023, 10'd0, 10'd1, 16'h0000, 1'b0);
        send_word(OP_CALIB, 10'd1022, 10'd1, 10'd0, 16'h0000, 1'b0);
        send_word(OP_MEAS, 10'd1023, 10'd0, 10'd0, 16'h0000, 1'b0);
        send_word(OP_MEAS, 10'd0, 10'd1023, 10'd1023, 16'h0000, 1'b0);
        drain();

        // Register extremes, zero values acting as one, values above their limits.
        run_setting(1, 1, 0, 4096, 150, PACE_SEND, 1'b0, -1, -1);
        run_setting(0, 0, 32767, 0, 150, PACE_RECV, 1'b0, -1, -1);
        run_setting(4, 32767, 410, 8191, 150, PACE_BOTH, 1'b0, 60, -1);
        // A long run left partway, then a sample count below what was already taken.
        run_setting(600, 3277, 200, 1500, 80, PACE_NONE, 1'b0, -1, -1);
        run_setting(5, 20000, 2000, 1000, 150, PACE_NONE, 1'b0, -1, 40);
        // Sample count above the limit: one full run of the largest size.
        run_setting(2047, 4096, 100, 2048, 1100, PACE_BOTH, 1'b1, -1, -1);
        for (int p = 0; p < 4; p++)
            run_setting($urandom_range(1, 8), $urandom_range(1, 32767), $urandom_range(0, 8000),
                        $urandom_range(0, 4096), 40, p, 1'b0, -1, -1);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d words still owed, expected 0, actual %0d", $time,
                     sb.pending(), sb.pending());
            sb.errors++;
        end
        $display("tb: covered %0d input words over %0d register settings, %0d outputs checked",
                 words_sent, settings_run, sb.checked);
        $display("tb: %0d calibrations completed, %0d measurements, %0d movement words",
                 sb.calibrations, sb.measures, sb.moves);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
